>>> rtl/cpu16_execute_unit_macros.svh
// assertion macros used by the checker module
`ifndef CPU16_EXECUTE_UNIT_MACROS_SVH
`define CPU16_EXECUTE_UNIT_MACROS_SVH

// property sampled at the rising clock edge, ignored while reset is held
`define CEU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every edge out of reset
`define CEU_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

>>> rtl/ceu_pkg.sv
// ----------------------------------------------------------------------------
// ceu_pkg
// Shared codes, flag positions and item types of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ceu_pkg;

    localparam logic [3:0] K_MOV    = 4'd0;
    localparam logic [3:0] K_ADD    = 4'd1;
    localparam logic [3:0] K_SUB    = 4'd2;
    localparam logic [3:0] K_CMP    = 4'd3;
    localparam logic [3:0] K_JE     = 4'd4;
    localparam logic [3:0] K_JB     = 4'd5;
    localparam logic [3:0] K_JP     = 4'd6;
    localparam logic [3:0] K_JNE    = 4'd7;
    localparam logic [3:0] K_LOOP   = 4'd8;
    localparam logic [3:0] K_LOOPNZ = 4'd9;

    localparam logic [1:0] DT_NONE = 2'd0;
    localparam logic [1:0] DT_REG  = 2'd1;
    localparam logic [1:0] DT_MEM  = 2'd2;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_REG  = 2'd1;
    localparam logic [1:0] SRC_IMM  = 2'd2;
    localparam logic [1:0] SRC_MEM  = 2'd3;

    localparam int F_C = 0;
    localparam int F_P = 1;
    localparam int F_A = 2;
    localparam int F_S = 3;
    localparam int F_O = 4;
    localparam int F_Z = 5;

    typedef struct packed {
        logic [3:0]  kind;
        logic        wide;
        logic [1:0]  dst_type;
        logic [4:0]  dst_reg;
        logic [1:0]  src_type;
        logic [4:0]  src_reg;
        logic [15:0] immediate;
        logic [3:0]  addr_base;
        logic [3:0]  addr_index;
        logic [15:0] displacement;
        logic [2:0]  inst_size;
        logic        op_alu;
        logic        op_sub;
        logic        wr_dst;
        logic        op_loop;
    } ceu_item_t;

    typedef struct packed {
        logic [15:0] next_ip;
        logic [5:0]  flag_bits;
        logic        reg_written;
        logic [3:0]  reg_slot;
        logic [15:0] reg_value;
    } ceu_result_t;

endpackage

>>> rtl/ceu_front.sv
// ----------------------------------------------------------------------------
// ceu_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ceu_front import ceu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [3:0]        kind,
    input  logic              wide,
    input  logic [1:0]        dst_type,
    input  logic [4:0]        dst_reg,
    input  logic [1:0]        src_type,
    input  logic [4:0]        src_reg,
    input  logic [15:0]       immediate,
    input  logic [3:0]        addr_base,
    input  logic [3:0]        addr_index,
    input  logic [15:0]       displacement,
    input  logic [2:0]        inst_size,
    output logic              q_valid,
    output ceu_item_t         q_item,
    input  logic              q_pop
);

    ceu_item_t  q_mem [2];
    ceu_item_t  dec;
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push_ok, pop_ok;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem[rp_reg];
    assign push_ok = push & ~full;
    assign pop_ok  = q_pop & q_valid;

    always_comb
    begin
        dec.kind         = kind;
        dec.wide         = wide;
        dec.dst_type     = dst_type;
        dec.dst_reg      = dst_reg;
        dec.src_type     = src_type;
        dec.src_reg      = src_reg;
        dec.immediate    = immediate;
        dec.addr_base    = addr_base;
        dec.addr_index   = addr_index;
        dec.displacement = displacement;
        dec.inst_size    = inst_size;
        dec.op_alu       = (kind == K_ADD) || (kind == K_SUB) || (kind == K_CMP);
        dec.op_sub       = (kind == K_SUB) || (kind == K_CMP);
        dec.wr_dst       = (kind == K_MOV) || (kind == K_ADD) || (kind == K_SUB);
        dec.op_loop      = (kind == K_LOOP) || (kind == K_LOOPNZ);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_ok && !pop_ok)
            cnt_next = cnt_reg + 2'd1;
        else if (pop_ok && !push_ok)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            q_mem[wp_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push_ok)
                wp_reg <= ~wp_reg;
            if (pop_ok)
                rp_reg <= ~rp_reg;
        end
    end

endmodule

>>> rtl/ceu_back.sv
// ----------------------------------------------------------------------------
// ceu_back
// Carries out queued items: address and memory read, then execute and
// write back; holds registers, flags, ip, byte memory and the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ceu_back import ceu_pkg::*;
#(
    parameter int MEM_BYTES  = 65536,
    parameter int REG_SLOTS  = 14,
    parameter int COUNT_SLOT = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  ceu_item_t   q_item,
    output logic        q_pop,
    output logic        clearing,
    input  logic        pop,
    output logic        empty,
    output ceu_result_t res
);

    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int BIDX_W     = ADDR_W - 1;
    localparam int BANK_DEPTH = MEM_BYTES / 2;
    localparam int SLOT_W     = $clog2(REG_SLOTS);
    localparam logic [BIDX_W-1:0] CLR_LAST = BIDX_W'(BANK_DEPTH - 1);
    localparam logic [SLOT_W-1:0] CS_IDX   = SLOT_W'(COUNT_SLOT);
    localparam logic [3:0]        CS_SLOT  = 4'(COUNT_SLOT);
    localparam logic [4:0]        NSLOTS   = 5'(REG_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_RD    = 3'b010,
        S_EX    = 3'b100
    } state_t;

    state_t st_reg, st_next;

    logic [15:0] rf_reg [REG_SLOTS];
    logic [5:0]  flag_reg;
    logic [15:0] ip_reg;
    ceu_item_t   cur_reg;

    // byte memory split into even and odd banks so a word is one access
    logic [7:0]        bank_e [BANK_DEPTH];
    logic [7:0]        bank_o [BANK_DEPTH];
    logic [7:0]        rd_e_reg, rd_o_reg;
    logic [BIDX_W-1:0] e_idx_reg, o_idx_reg, clr_reg;
    logic              lo_odd_reg;

    // address stage
    logic [3:0]        tb_idx, ti_idx;
    logic [15:0]       base_v, index_v, addr16;
    logic [ADDR_W-1:0] maddr, maddr1;
    logic [BIDX_W-1:0] rd_e_idx, rd_o_idx, w_e_idx, w_o_idx;
    logic              mem_re, we_e, we_o;
    logic [7:0]        wd_e, wd_o;

    // execute stage
    logic [7:0]  lo_b, hi_b;
    logic [15:0] mem_v, s_full, d_full, s_v, d_v, a, b, alu_res, op_val, new_val, cnt_new;
    logic [15:0] ip_seq, ip_new;
    logic [3:0]  s_slot, d_slot;
    logic        s_ok, d_ok, aux, carry, ovf, jump, wr_reg, wr_mem, ex_fire;
    logic [16:0] add17, sub17;
    logic [4:0]  aux5;
    logic [5:0]  flag_new;
    ceu_result_t ex_res;

    // result queue
    ceu_result_t o_mem [2];
    logic [1:0]  o_cnt_reg, o_cnt_next;
    logic        o_wp_reg, o_rp_reg, o_pop_ok;

    assign clearing = (st_reg == S_CLEAR);

    always_comb
    begin
        tb_idx = q_item.addr_base - 4'd1;
        ti_idx = q_item.addr_index - 4'd1;
        base_v = ((q_item.addr_base != 4'd0) && ({1'b0, tb_idx} < NSLOTS)) ?
                 rf_reg[tb_idx[SLOT_W-1:0]] : 16'h0000;
        index_v = ((q_item.addr_index != 4'd0) && ({1'b0, ti_idx} < NSLOTS)) ?
                  rf_reg[ti_idx[SLOT_W-1:0]] : 16'h0000;
        addr16 = base_v + index_v + q_item.displacement;
        maddr  = addr16[ADDR_W-1:0];
        maddr1 = maddr + ADDR_W'(1);
        rd_e_idx = maddr[0] ? maddr1[ADDR_W-1:1] : maddr[ADDR_W-1:1];
        rd_o_idx = maddr[0] ? maddr[ADDR_W-1:1]  : maddr1[ADDR_W-1:1];
    end

    always_comb
    begin
        lo_b  = lo_odd_reg ? rd_o_reg : rd_e_reg;
        hi_b  = lo_odd_reg ? rd_e_reg : rd_o_reg;
        mem_v = cur_reg.wide ? {hi_b, lo_b} : {8'h00, lo_b};

        s_slot = cur_reg.src_reg[4:1];
        s_ok   = ({1'b0, s_slot} < NSLOTS);
        s_full = s_ok ? rf_reg[s_slot[SLOT_W-1:0]] : 16'h0000;
        s_v    = cur_reg.wide ? s_full :
                 (cur_reg.src_reg[0] ? {8'h00, s_full[15:8]} : {8'h00, s_full[7:0]});

        d_slot = cur_reg.dst_reg[4:1];
        d_ok   = ({1'b0, d_slot} < NSLOTS);
        d_full = d_ok ? rf_reg[d_slot[SLOT_W-1:0]] : 16'h0000;
        d_v    = cur_reg.wide ? d_full :
                 (cur_reg.dst_reg[0] ? {8'h00, d_full[15:8]} : {8'h00, d_full[7:0]});

        unique case (cur_reg.src_type)
            SRC_REG: b = s_v;
            SRC_IMM: b = cur_reg.immediate;
            SRC_MEM: b = mem_v;
            default: b = 16'h0000;
        endcase

        if (cur_reg.dst_type == DT_REG)
            a = d_v;
        else if ((cur_reg.dst_type == DT_MEM) && cur_reg.op_alu)
            a = mem_v;
        else
            a = 16'h0000;

        add17 = {1'b0, a} + {1'b0, b};
        sub17 = {1'b0, a} - {1'b0, b};
        aux5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        if (cur_reg.op_sub)
        begin
            alu_res = sub17[15:0];
            carry   = sub17[16];
            aux     = (a[3:0] < b[3:0]);
            ovf     = (a[15] != b[15]) && (sub17[15] != a[15]);
        end
        else
        begin
            alu_res = add17[15:0];
            carry   = add17[16];
            aux     = aux5[4];
            ovf     = (a[15] == b[15]) && (add17[15] != a[15]);
        end

        if (cur_reg.op_alu)
        begin
            flag_new      = 6'd0;
            flag_new[F_C] = carry;
            flag_new[F_P] = ~^alu_res[7:0];
            flag_new[F_A] = aux;
            flag_new[F_S] = alu_res[15];
            flag_new[F_O] = ovf;
            flag_new[F_Z] = (alu_res == 16'h0000);
        end
        else
            flag_new = flag_reg;

        // mov passes the source through, other writers take the ALU result
        if (cur_reg.kind == K_MOV)
            op_val = b;
        else
            op_val = alu_res;
        new_val = op_val;
        if (!cur_reg.wide)
            new_val = cur_reg.dst_reg[0] ? {op_val[7:0], d_full[7:0]} :
                      {d_full[15:8], op_val[7:0]};

        wr_reg  = cur_reg.wr_dst && (cur_reg.dst_type == DT_REG) && d_ok;
        wr_mem  = cur_reg.wr_dst && (cur_reg.dst_type == DT_MEM);
        cnt_new = rf_reg[CS_IDX] - 16'd1;

        unique case (cur_reg.kind)
            K_JE:     jump = flag_reg[F_Z];
            K_JB:     jump = flag_reg[F_C];
            K_JP:     jump = flag_reg[F_P];
            K_JNE:    jump = ~flag_reg[F_Z];
            K_LOOP:   jump = (cnt_new != 16'h0000);
            K_LOOPNZ: jump = (cnt_new != 16'h0000) && !flag_reg[F_Z];
            default:  jump = 1'b0;
        endcase

        ip_seq = ip_reg + {13'd0, cur_reg.inst_size};
        ip_new = jump ? ip_seq + cur_reg.immediate : ip_seq;

        ex_res.next_ip     = ip_new;
        ex_res.flag_bits   = flag_new;
        ex_res.reg_written = wr_reg | cur_reg.op_loop;
        if (cur_reg.op_loop)
        begin
            ex_res.reg_slot  = CS_SLOT;
            ex_res.reg_value = cnt_new;
        end
        else if (wr_reg)
        begin
            ex_res.reg_slot  = d_slot;
            ex_res.reg_value = new_val;
        end
        else
        begin
            ex_res.reg_slot  = 4'd0;
            ex_res.reg_value = 16'h0000;
        end
    end

    assign ex_fire = (st_reg == S_EX) && (o_cnt_reg != 2'd2);
    assign q_pop   = (st_reg == S_RD) && q_valid;
    assign mem_re  = q_pop;

    always_comb
    begin
        if (st_reg == S_CLEAR)
        begin
            we_e    = 1'b1;
            we_o    = 1'b1;
            w_e_idx = clr_reg;
            w_o_idx = clr_reg;
            wd_e    = 8'h00;
            wd_o    = 8'h00;
        end
        else
        begin
            we_e    = ex_fire && wr_mem && (!lo_odd_reg || cur_reg.wide);
            we_o    = ex_fire && wr_mem && (lo_odd_reg || cur_reg.wide);
            w_e_idx = e_idx_reg;
            w_o_idx = o_idx_reg;
            wd_e    = lo_odd_reg ? op_val[15:8] : op_val[7:0];
            wd_o    = lo_odd_reg ? op_val[7:0]  : op_val[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_e)
            bank_e[w_e_idx] <= wd_e;
        if (mem_re)
            rd_e_reg <= bank_e[rd_e_idx];
    end

    always_ff @(posedge clk)
    begin
        if (we_o)
            bank_o[w_o_idx] <= wd_o;
        if (mem_re)
            rd_o_reg <= bank_o[rd_o_idx];
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_CLEAR: if (clr_reg == CLR_LAST) st_next = S_RD;
            S_RD:    if (q_valid) st_next = S_EX;
            S_EX:    if (ex_fire) st_next = S_RD;
            default: st_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg    <= q_item;
            e_idx_reg  <= rd_e_idx;
            o_idx_reg  <= rd_o_idx;
            lo_odd_reg <= maddr[0];
        end
        if (ex_fire)
            o_mem[o_wp_reg] <= ex_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLEAR;
            clr_reg  <= '0;
            flag_reg <= 6'd0;
            ip_reg   <= 16'h0000;
            for (int i = 0; i < REG_SLOTS; i++)
                rf_reg[i] <= 16'h0000;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_CLEAR)
                clr_reg <= clr_reg + BIDX_W'(1);
            if (ex_fire)
            begin
                flag_reg <= flag_new;
                ip_reg   <= ip_new;
                if (cur_reg.op_loop)
                    rf_reg[CS_IDX] <= cnt_new;
                else if (wr_reg)
                    rf_reg[d_slot[SLOT_W-1:0]] <= new_val;
            end
        end
    end

    assign empty    = (o_cnt_reg == 2'd0);
    assign res      = o_mem[o_rp_reg];
    assign o_pop_ok = pop & ~empty;

    always_comb
    begin
        o_cnt_next = o_cnt_reg;
        if (ex_fire && !o_pop_ok)
            o_cnt_next = o_cnt_reg + 2'd1;
        else if (o_pop_ok && !ex_fire)
            o_cnt_next = o_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_cnt_reg <= 2'd0;
            o_wp_reg  <= 1'b0;
            o_rp_reg  <= 1'b0;
        end
        else
        begin
            o_cnt_reg <= o_cnt_next;
            if (ex_fire)
                o_wp_reg <= ~o_wp_reg;
            if (o_pop_ok)
                o_rp_reg <= ~o_rp_reg;
        end
    end

endmodule

>>> rtl/cpu16_execute_unit.sv
// path: front queue, then execute stage with memory read, then result queue
// pacing: a new item is taken only after the last one has executed, as the
//   back end alternates read and execute states
// reset: registers, flags and ip clear at once; the memory is then swept
//   to zero one bank entry at a time, with full held high meanwhile
// ----------------------------------------------------------------------------
// cpu16_execute_unit
// Executes decoded 16-bit instructions: front queue plus execute back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu16_execute_unit import ceu_pkg::*;
#(
    parameter int MEM_BYTES  = 65536,
    parameter int REG_SLOTS  = 14,
    parameter int COUNT_SLOT = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         kind,
    input  logic               wide,
    input  logic [1:0]         dst_type,
    input  logic [4:0]         dst_reg,
    input  logic [1:0]         src_type,
    input  logic [4:0]         src_reg,
    input  logic signed [15:0] immediate,
    input  logic [3:0]         addr_base,
    input  logic [3:0]         addr_index,
    input  logic signed [15:0] displacement,
    input  logic [2:0]         inst_size,
    input  logic               pop,
    output logic               empty,
    output logic [15:0]        next_ip,
    output logic [5:0]         flag_bits,
    output logic               reg_written,
    output logic [3:0]         reg_slot,
    output logic [15:0]        reg_value
);

    logic        f_full, clearing, q_valid, q_pop;
    ceu_item_t   q_item;
    ceu_result_t res;

    assign full = f_full | clearing;

    ceu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push & ~clearing),
        .full         (f_full),
        .kind         (kind),
        .wide         (wide),
        .dst_type     (dst_type),
        .dst_reg      (dst_reg),
        .src_type     (src_type),
        .src_reg      (src_reg),
        .immediate    ($unsigned(immediate)),
        .addr_base    (addr_base),
        .addr_index   (addr_index),
        .displacement ($unsigned(displacement)),
        .inst_size    (inst_size),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    ceu_back #(
        .MEM_BYTES  (MEM_BYTES),
        .REG_SLOTS  (REG_SLOTS),
        .COUNT_SLOT (COUNT_SLOT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    assign next_ip     = res.next_ip;
    assign flag_bits   = res.flag_bits;
    assign reg_written = res.reg_written;
    assign reg_slot    = res.reg_slot;
    assign reg_value   = res.reg_value;

endmodule

>>> rtl/ceu_checker.sv
// ----------------------------------------------------------------------------
// ceu_checker
// Port-level checks on the result side of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu16_execute_unit_macros.svh"

module ceu_checker
#(
    parameter int REG_SLOTS = 14
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        pop,
    input logic        empty,
    input logic [15:0] next_ip,
    input logic        reg_written,
    input logic [3:0]  reg_slot,
    input logic [15:0] reg_value
);

    // an item with no register write reports slot and value as zero
    `CEU_ASSERT_IMPL(a_nowrite_zero, !empty && !reg_written, (reg_slot == 4'd0) && (reg_value == 16'h0000), "unwritten result not zero")
    `CEU_ASSERT_IMPL(a_slot_range, !empty && reg_written, {1'b0, reg_slot} < 5'(REG_SLOTS), "written slot out of range")
    `CEU_ASSERT(a_hold_valid, (!empty && !pop) |=> !empty, "result dropped while stalled")
    `CEU_ASSERT(a_hold_ip, (!empty && !pop) |=> $stable(next_ip), "next_ip changed while stalled")

endmodule

bind cpu16_execute_unit ceu_checker #(.REG_SLOTS(REG_SLOTS)) u_ceu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .empty       (empty),
    .next_ip     (next_ip),
    .reg_written (reg_written),
    .reg_slot    (reg_slot),
    .reg_value   (reg_value)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Execute unit bench: directed and random decoded instructions against a behavioral model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ceu_pkg::*;

    localparam int NUM_SLOTS = 14;
    localparam int CNT_SLOT  = 2;
    localparam logic [3:0] K_OTHER = 4'd10;
    localparam logic [3:0] K_SPARE = 4'd15;
    localparam logic [1:0] DT_BAD  = 2'd3;

    class exec_scoreboard;
        logic [15:0] regs [NUM_SLOTS];
        logic [7:0]  mem [int];
        logic [5:0]  flags;
        logic [15:0] ip;
        ceu_result_t pending [$];
        int          errors;
        int          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            flags   = '0;
            ip      = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [7:0] rdb(logic [15:0] a);
            return mem.exists(a) ? mem[a] : 8'h00;
        endfunction

        function logic [15:0] rdm(logic [15:0] a, logic w);
            logic [15:0] hi_a;
            hi_a = a + 16'd1;
            return w ? {rdb(hi_a), rdb(a)} : {8'h00, rdb(a)};
        endfunction

        function logic [15:0] rdr(logic [4:0] code, logic w);
            int s;
            s = code[4:1];
            if (s >= NUM_SLOTS) return '0;
            if (w) return regs[s];
            return code[0] ? {8'h00, regs[s][15:8]} : {8'h00, regs[s][7:0]};
        endfunction

        function logic [15:0] addr_term(logic [3:0] t);
            if (t == 0 || t - 1 >= NUM_SLOTS) return '0;
            return regs[t - 1];
        endfunction

        function logic parity_bit(logic [15:0] v);
            return ~^v[7:0];
        endfunction

        // executes one instruction and queues the result it must produce
        function void note_instruction(ceu_item_t it);
            logic [15:0] addr, a, b, res, hi_addr;
            logic [16:0] sum;
            logic        wr, jmp;
            int          slot;
            ceu_result_t r;
            addr = addr_term(it.addr_base) + addr_term(it.addr_index) + it.displacement;
            hi_addr = addr + 16'd1;
            a = '0; b = '0; res = '0; wr = 0; jmp = 0; slot = 0;
            ip = ip + it.inst_size;
            case (it.src_type)
                SRC_REG: b = rdr(it.src_reg, it.wide);
                SRC_IMM: b = it.immediate;
                SRC_MEM: b = rdm(addr, it.wide);
                default: b = '0;
            endcase
            if (it.dst_type == DT_REG) a = rdr(it.dst_reg, it.wide);
            else if (it.dst_type == DT_MEM && it.kind >= K_ADD && it.kind <= K_CMP)
                a = rdm(addr, it.wide);
            if (it.kind == K_MOV) res = b;
            else if (it.kind <= K_CMP) begin
                logic [5:0] f;
                f = '0;
                if (it.kind == K_ADD) begin
                    sum = a + b;
                    res = sum[15:0];
                    f[F_C] = sum[16];
                    f[F_A] = ({1'b0, a[3:0]} + b[3:0]) > 15;
                    f[F_O] = (a[15] == b[15]) && (res[15] != a[15]);
                end
                else begin
                    res = a - b;
                    f[F_C] = a < b;
                    f[F_A] = a[3:0] < b[3:0];
                    f[F_O] = (a[15] != b[15]) && (res[15] != a[15]);
                end
                f[F_P] = parity_bit(res);
                f[F_S] = res[15];
                f[F_Z] = res == 0;
                flags = f;
            end
            if (it.kind <= K_SUB) begin
                if (it.dst_type == DT_REG) begin
                    slot = it.dst_reg[4:1];
                    if (slot < NUM_SLOTS) begin
                        if (it.wide) regs[slot] = res;
                        else if (it.dst_reg[0]) regs[slot][15:8] = res[7:0];
                        else regs[slot][7:0] = res[7:0];
                        wr = 1;
                    end
                end
                else if (it.dst_type == DT_MEM) begin
                    mem[addr] = res[7:0];
                    if (it.wide) mem[hi_addr] = res[15:8];
                end
            end
            else if (it.kind == K_JE) jmp = flags[F_Z];
            else if (it.kind == K_JB) jmp = flags[F_C];
            else if (it.kind == K_JP) jmp = flags[F_P];
            else if (it.kind == K_JNE) jmp = !flags[F_Z];
            else if (it.kind == K_LOOP || it.kind == K_LOOPNZ) begin
                slot = CNT_SLOT;
                regs[slot] = regs[slot] - 16'd1;
                jmp = regs[slot] != 0;
                if (it.kind == K_LOOPNZ && flags[F_Z]) jmp = 0;
                wr = 1;
            end
            if (jmp) ip = ip + it.immediate;
            r.next_ip     = ip;
            r.flag_bits   = flags;
            r.reg_written = wr;
            r.reg_slot    = wr ? slot[3:0] : 4'd0;
            r.reg_value   = wr ? regs[slot] : 16'd0;
            pending.push_back(r);
        endfunction

        function void check_result(ceu_result_t got);
            ceu_result_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.next_ip !== exp.next_ip) begin
                $display("%0t: next_ip exp %h got %h", $realtime, exp.next_ip, got.next_ip);
                errors++;
            end
            if (got.flag_bits !== exp.flag_bits) begin
                $display("%0t: flag_bits exp %h got %h", $realtime, exp.flag_bits,
                         got.flag_bits);
                errors++;
            end
            if (got.reg_written !== exp.reg_written) begin
                $display("%0t: reg_written exp %b got %b", $realtime, exp.reg_written,
                         got.reg_written);
                errors++;
            end
            if (got.reg_slot !== exp.reg_slot) begin
                $display("%0t: reg_slot exp %h got %h", $realtime, exp.reg_slot, got.reg_slot);
                errors++;
            end
            if (got.reg_value !== exp.reg_value) begin
                $display("%0t: reg_value exp %h got %h", $realtime, exp.reg_value,
                         got.reg_value);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n, push, pop;
    logic        full, empty;
    ceu_item_t   item;
    logic [15:0] next_ip, reg_value;
    logic [5:0]  flag_bits;
    logic        reg_written;
    logic [3:0]  reg_slot;
    logic        feed_done;

    exec_scoreboard sb;

    cpu16_execute_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .kind(item.kind), .wide(item.wide), .dst_type(item.dst_type),
        .dst_reg(item.dst_reg), .src_type(item.src_type), .src_reg(item.src_reg),
        .immediate(item.immediate), .addr_base(item.addr_base),
        .addr_index(item.addr_index), .displacement(item.displacement),
        .inst_size(item.inst_size), .pop(pop), .empty(empty),
        .next_ip(next_ip), .flag_bits(flag_bits), .reg_written(reg_written),
        .reg_slot(reg_slot), .reg_value(reg_value)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    task automatic send_item(ceu_item_t it, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(negedge clk);
        end
        push <= 1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_instruction(it);
        @(negedge clk);
    endtask

    function automatic ceu_item_t plain_item(logic [3:0] k);
        ceu_item_t it;
        it = '0;
        it.kind = k;
        it.wide = 1;
        it.inst_size = 3'd2;
        return it;
    endfunction

    function automatic ceu_item_t random_item();
        ceu_item_t it;
        int pick;
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < 30) it.kind = K_MOV;
        else if (pick < 75) it.kind = 4'($urandom_range(1, 3));
        else if (pick < 93) it.kind = 4'($urandom_range(4, 9));
        else it.kind = 4'($urandom_range(10, 15));
        it.wide     = 1'($urandom_range(0, 1));
        it.dst_type = 2'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3)
                                                    : $urandom_range(1, 2));
        it.dst_reg  = 5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 27));
        it.src_type = 2'($urandom_range(0, 3));
        it.src_reg  = 5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 27));
        it.immediate = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 15) - 8);
        it.addr_base  = 4'($urandom_range(0, 15));
        it.addr_index = 4'($urandom_range(0, 15));
        // keep addresses in a small window most of the time so reads hit written bytes
        it.displacement = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 31));
        it.inst_size = 3'($urandom_range(0, 7));
        return it;
    endfunction

    initial begin
        ceu_item_t it;
        sb = new();
        rst_n = 0;
        push = 0;
        item = '0;
        feed_done = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, every kind, a high byte half, wrap, out-of-file slots
        it = plain_item(K_MOV); it.dst_type = DT_REG; it.dst_reg = 5'd4;
        it.src_type = SRC_IMM; it.immediate = 16'hFFFF; send_item(it, 0);
        it.kind = K_ADD; it.immediate = 16'h0001; send_item(it, 0);
        it.kind = K_SUB; it.immediate = 16'h8000; send_item(it, 0);
        it.kind = K_CMP; it.immediate = 16'h7FFF; send_item(it, 0);
        it.wide = 0; it.dst_reg = 5'd5; it.kind = K_ADD; it.immediate = 16'h00F8;
        send_item(it, 0);
        it.dst_reg = 5'd31; it.kind = K_MOV; send_item(it, 0);
        it = plain_item(K_MOV); it.dst_type = DT_MEM; it.src_type = SRC_IMM;
        it.immediate = 16'hA55A; it.displacement = 16'hFFFF; send_item(it, 0);
        it.kind = K_ADD; it.addr_base = 4'd3; it.addr_index = 4'd15; send_item(it, 0);
        it = plain_item(K_MOV); it.dst_type = DT_REG; it.dst_reg = 5'd2;
        it.src_type = SRC_MEM; it.displacement = 16'hFFFF; send_item(it, 0);
        it.dst_type = DT_BAD; send_item(it, 0);
        for (int k = 4; k <= 9; k++) begin
            it = plain_item(4'(k)); it.immediate = 16'h8000; it.inst_size = 3'd7;
            send_item(it, 0);
        end
        it = plain_item(K_MOV); it.dst_type = DT_REG; it.dst_reg = 5'd4;
        it.src_type = SRC_IMM; it.immediate = 16'd1; send_item(it, 0);
        it = plain_item(K_LOOP); it.immediate = 16'hFFF0; send_item(it, 0);
        it = plain_item(K_OTHER); it.inst_size = 3'd0; send_item(it, 0);
        it.kind = K_SPARE; send_item(it, 0);
        it = plain_item(K_SUB); it.dst_type = DT_NONE; it.src_type = SRC_NONE;
        send_item(it, 0);

        for (int n = 0; n < 950; n++)
            send_item(random_item(), $urandom_range(0, 3) != 0);
        push <= 0;
        feed_done = 1;
    end

    initial begin
        int gap;
        pop = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1;
            @(posedge clk);
            while (empty) @(posedge clk);
            sb.check_result('{next_ip, flag_bits, reg_written, reg_slot, reg_value});
        end
    end

    initial begin
        @(posedge feed_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("checked %0d results from directed and random instruction mixes",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end
endmodule
